/* design/nbr_pkg.sv */
// ---------------------------------------------------------------------------
// nbr_pkg
// Types, codes and the crc-16 byte update shared by the nine-bit packet
// receiver modules.
// ---------------------------------------------------------------------------
package nbr_pkg;

	localparam int MAX_PAYLOAD = 256;
	localparam logic [15:0] CRC_INIT = 16'hffff;
	// header and length in front, two crc bytes behind
	localparam logic [8:0] FRAME_OVERHEAD = 9'd4;

	typedef enum logic [1:0] {
		OP_WORD  = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		EV_NONE    = 2'd0,
		EV_GOOD    = 2'd1,
		EV_OTHER   = 2'd2,
		EV_CRC_BAD = 2'd3
	} event_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [8:0] serial_word;
		logic [5:0] read_index;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [1:0]  packet_event;
		logic        reply_request;
		logic [2:0]  reply_dest;
		logic [31:0] packets_good;
		logic [31:0] packets_crc_bad;
	} out_item_t;

	// parser result, everything but the read byte
	typedef struct packed {
		logic [1:0]  packet_event;
		logic        reply_request;
		logic [2:0]  reply_dest;
		logic [31:0] packets_good;
		logic [31:0] packets_crc_bad;
	} parse_res_t;

	// request from the parser to the payload store
	typedef struct packed {
		logic       stage_we;
		logic [8:0] stage_pos;
		logic [7:0] stage_byte;
		logic       commit;
		logic [8:0] commit_len;
		logic       rd_en;
		logic       rd_sel;
		logic [5:0] rd_idx;
	} store_cmd_t;

	function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] x;
		x = crc[15:8] ^ b;
		x = x ^ {4'd0, x[7:4]};
		crc_add = {crc[7:0], 8'd0} ^ {x[3:0], 12'd0} ^ {3'd0, x, 5'd0} ^ {8'd0, x};
	endfunction

endpackage

/* design/nbr_ram.sv */
// ---------------------------------------------------------------------------
// nbr_ram
// Generic single-write, single-read ram with a registered read port.
// ---------------------------------------------------------------------------
module nbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* design/nbr_parser.sv */
// ---------------------------------------------------------------------------
// nbr_parser
// Frame parser: header match, length, crc-16 check, packet counters.
// ---------------------------------------------------------------------------
module nbr_parser import nbr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  in_item_t   item,
	input  logic [2:0] node_address,
	input  logic       is_slave,
	output store_cmd_t cmd,
	output parse_res_t res
);

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [8:0]  cnt_q, cnt_d;
	logic [8:0]  total_q, total_d;
	logic [2:0]  sender_q, sender_d;
	logic [1:0]  mode_q, mode_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0]  low_q, low_d;
	logic [31:0] good_q, good_d;
	logic [31:0] bad_q, bad_d;

	logic [7:0]  b;
	logic [8:0]  cnt_inc;
	logic [8:0]  len9;
	logic [15:0] crc_b;

	assign b       = item.serial_word[7:0];
	assign cnt_inc = cnt_q + 9'd1;
	assign len9    = (b == 8'd0) ? 9'(MAX_PAYLOAD) : {1'b0, b};
	assign crc_b   = crc_add(crc_q, b);

	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		total_d  = total_q;
		sender_d = sender_q;
		mode_d   = mode_q;
		crc_d    = crc_q;
		low_d    = low_q;
		good_d   = good_q;
		bad_d    = bad_q;

		cmd            = '0;
		cmd.rd_en      = take;
		cmd.rd_sel     = take && (item.opcode == OP_READ);
		cmd.rd_idx     = item.read_index;
		cmd.stage_byte = b;
		cmd.stage_pos  = cnt_inc - 9'd3;
		cmd.commit_len = total_q - FRAME_OVERHEAD;

		res.packet_event  = EV_NONE;
		res.reply_request = 1'b0;
		res.reply_dest    = 3'd0;

		if (take && item.opcode == OP_CLEAR) begin
			good_d = '0;
			bad_d  = '0;
		end

		if (take && item.opcode == OP_WORD) begin
			if (item.serial_word[8]) begin
				// headers for other nodes leave a packet in progress alone
				if (item.serial_word[2:0] == node_address) begin
					sender_d = item.serial_word[5:3];
					mode_d   = item.serial_word[7:6];
					crc_d    = crc_add(CRC_INIT, b);
					cnt_d    = 9'd1;
					phase_d  = PH_LEN;
				end
			end else begin
				unique case (phase_q)
					PH_LEN: begin
						total_d = len9 + FRAME_OVERHEAD;
						crc_d   = crc_b;
						cnt_d   = 9'd2;
						phase_d = PH_BODY;
					end
					PH_BODY: begin
						if (cnt_q >= 9'(MAX_PAYLOAD + 4)) begin
							phase_d = PH_IDLE;
						end else begin
							cnt_d = cnt_inc;
							if ({1'b0, cnt_inc} + 10'd2 <= {1'b0, total_q}) begin
								crc_d        = crc_b;
								cmd.stage_we = 1'b1;
							end else if ({1'b0, cnt_inc} + 10'd1 == {1'b0, total_q}) begin
								low_d = b;
							end else begin
								if (low_q == crc_q[7:0] && b == crc_q[15:8]) begin
									if (mode_q == 2'd0) begin
										cmd.commit        = 1'b1;
										good_d            = good_q + 32'd1;
										res.reply_request = is_slave;
										res.packet_event  = EV_GOOD;
									end else begin
										res.packet_event = EV_OTHER;
									end
									res.reply_dest = sender_q;
								end else begin
									bad_d            = bad_q + 32'd1;
									res.packet_event = EV_CRC_BAD;
								end
								phase_d = PH_IDLE;
							end
						end
					end
					default: begin
						// data word with no packet open is dropped
					end
				endcase
			end
		end

		res.packets_good    = good_d;
		res.packets_crc_bad = bad_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			total_q  <= '0;
			sender_q <= '0;
			mode_q   <= '0;
			crc_q    <= CRC_INIT;
			low_q    <= '0;
			good_q   <= '0;
			bad_q    <= '0;
		end else begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			total_q  <= total_d;
			sender_q <= sender_d;
			mode_q   <= mode_d;
			crc_q    <= crc_d;
			low_q    <= low_d;
			good_q   <= good_d;
			bad_q    <= bad_d;
		end
	end

endmodule

/* design/nbr_store.sv */
// ---------------------------------------------------------------------------
// nbr_store
// Payload store: two banks in one ram, per-byte bank select and valid bit,
// so a commit is a bank flip rather than a copy.
// ---------------------------------------------------------------------------
module nbr_store import nbr_pkg::*; #(
	parameter int STORE_BYTES = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  store_cmd_t cmd,
	output logic [7:0] rd_data
);

	localparam int SA = $clog2(STORE_BYTES);
	localparam int NE = 2 ** SA;

	// bank holding the committed copy of each byte
	logic [NE-1:0] bank_q;
	logic [NE-1:0] vld_q;
	logic          rd_ok_q;
	logic [7:0]    ram_rdata;

	logic [8:0]    idx_ext;
	logic [SA-1:0] wpos;
	logic [SA-1:0] rpos;
	logic          wr_en;
	logic          rd_hit;

	assign idx_ext = {3'd0, cmd.rd_idx};
	assign wpos    = cmd.stage_pos[SA-1:0];
	assign rpos    = idx_ext[SA-1:0];
	assign wr_en   = cmd.stage_we && (cmd.stage_pos < 9'(STORE_BYTES));
	assign rd_hit  = cmd.rd_sel && (idx_ext < 9'(STORE_BYTES)) && vld_q[rpos];

	// staging always goes to the bank not holding the committed byte
	nbr_ram #(
		.WIDTH(8),
		.DEPTH(2 * NE)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr ({~bank_q[wpos], wpos}),
		.wdata (cmd.stage_byte),
		.re    (cmd.rd_en),
		.raddr ({bank_q[rpos], rpos}),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= '0;
			vld_q   <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_ok_q <= rd_hit;
			end
			if (cmd.commit) begin
				for (int i = 0; i < NE; i++) begin
					if (i < STORE_BYTES && 9'(i) < cmd.commit_len) begin
						bank_q[i] <= ~bank_q[i];
						vld_q[i]  <= 1'b1;
					end
				end
			end
		end
	end

	assign rd_data = rd_ok_q ? ram_rdata : 8'd0;

endmodule

/* design/nine_bit_packet_receiver_crc16_top.sv */
// ---------------------------------------------------------------------------
// nine_bit_packet_receiver_crc16_top
// Multidrop 9-bit uart packet receiver with crc-16 check and payload store.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries one request per item:
// a serial word, a read of a stored payload byte, a counter clear or a no-op.
// Output channel (out_valid/out_ready/out_data) returns exactly one result
// per request, in order, with event code, reply request and both counters.
// Requests are taken one per cycle, sustained, while the output does not stall.
// The parse result and the registered ram read are captured at the accepting
// edge and the output register loads from them when it is free, so a result
// passes the parse stage register and then the output register.
// A stalled receiver holds the output register; one more request can still
// enter the parse stage, after which in_ready drops until out_ready returns.
// Payload bytes live in one ram split into a staging and a committed bank
// per byte; a good packet flips the bank bits, so no copy cycles are needed.
// Reset clears parser state, counters and the per-byte valid bits, so the
// store reads as zero; node_address resets to 1 and is_slave to 0.
// Registers sit on an apb port: node_address at 0x0, is_slave at 0x4.
// ---------------------------------------------------------------------------
module nine_bit_packet_receiver_crc16_top import nbr_pkg::*; #(
	parameter int STORE_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_item_t   out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_NODE_ADDR = 1'b0;
	localparam logic REG_IS_SLAVE  = 1'b1;

	logic       reg_sel;
	logic [2:0] node_addr_q;
	logic       slave_q;

	logic       take;
	logic       move;
	logic       valid_s1;
	parse_res_t res;
	parse_res_t res_s1;
	store_cmd_t cmd;
	logic [7:0] rd_data;
	out_item_t  out_q;
	logic       out_valid_q;

	// apb registers
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign prdata  = (reg_sel == REG_NODE_ADDR) ? {29'd0, node_addr_q} : {31'd0, slave_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_addr_q <= 3'd1;
			slave_q     <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (reg_sel == REG_IS_SLAVE) begin
				slave_q <= pwdata[0];
			end else begin
				node_addr_q <= pwdata[2:0];
			end
		end
	end

	// handshake: parse stage then output register
	assign move     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || move;
	assign take     = in_valid && in_ready;

	nbr_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.item         (in_data),
		.node_address (node_addr_q),
		.is_slave     (slave_q),
		.cmd          (cmd),
		.res          (res)
	);

	nbr_store #(
		.STORE_BYTES(STORE_BYTES)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res;
		end
		if (move) begin
			out_q.read_data       <= rd_data;
			out_q.packet_event    <= res_s1.packet_event;
			out_q.reply_request   <= res_s1.reply_request;
			out_q.reply_dest      <= res_s1.reply_dest;
			out_q.packets_good    <= res_s1.packets_good;
			out_q.packets_crc_bad <= res_s1.packets_crc_bad;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
